[hw/rtl/vrrq_pkg.sv]
// Shared constants for the variable record ring queue: request kinds,
// status codes, header and reserve sizes. No dependencies.
`default_nettype none
package vrrq_pkg;

  localparam int RING_BYTES_DEF = 1024;
  localparam int HEADER_BYTES   = 4;
  localparam int RESERVE_BYTES  = 8;
  localparam int LIMIT_CAP      = 64;
  localparam int LIMIT_RESET    = 64;

  localparam int REQ_W  = 3;
  localparam int LEN_W  = 7;
  localparam int BYTE_W = 8;
  localparam int PEND_W = 6;
  localparam int STAT_W = 3;
  localparam int FREE_W = 10;

  localparam logic [REQ_W-1:0] REQ_OPEN    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DATA    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PEEK    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DISCARD = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_LEN = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_ROOM = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_OPEN = 3'd4;

endpackage
`default_nettype wire

[hw/rtl/variable_record_ring_queue_core.sv]
// Variable record ring queue: length-prefixed records in a byte ring.
// Depends on vrrq_pkg and vrrq_ram.
//
// Requests arrive on in_* and each produces one or more result words on
// out_*. push_open, push_data, unused kinds and any reply on an empty queue
// are answered straight from the idle state; discard first reads the header
// byte; pop and peek read the header byte and then stream the payload bytes,
// the pace being set by the single read port of the byte RAM and by out_tready.
// A new request is taken only once the previous result word has left or
// is leaving. The ring is not cleared after reset; only written bytes are
// ever read. Only the low header byte is stored, since lengths never
// exceed 64; the other three header bytes are skipped over.
`default_nettype none
module variable_record_ring_queue_core #(
  parameter int RING_BYTES = vrrq_pkg::RING_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // config: record_limit
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data,
  // in_tdata: [6:0] record_length, [14:7] data_byte, [15] zero
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,
  // in_tuser: [2:0] req_type
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_tdata: [7:0] out_byte, [14:8] front_length, [24:15] free_bytes,
  //            [25] is_empty, [31:26] zero
  output logic [31:0]      out_tdata,
  output logic             out_tlast,
  // out_tuser: [2:0] status
  output logic [2:0]       out_tuser
);

  localparam int PW = $clog2(RING_BYTES);
  localparam int SW = (PW + 1 > 8) ? PW + 1 : 8;
  localparam int LW = vrrq_pkg::LEN_W;
  localparam int BW = vrrq_pkg::BYTE_W;
  localparam int NW = vrrq_pkg::PEND_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HDR  = 2'd1;
  localparam logic [1:0] S_STRM = 2'd2;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [LW-1:0] n);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(n);
    if (s >= SW'(RING_BYTES)) begin
      s = s - SW'(RING_BYTES);
    end
    return s[PW-1:0];
  endfunction

  logic [1:0]    state_r, state_nxt;
  logic [PW-1:0] read_r, read_nxt;
  logic [PW-1:0] commit_r, commit_nxt;
  logic [PW-1:0] fill_r, fill_nxt;
  logic [NW-1:0] pend_r, pend_nxt;
  logic [LW-1:0] limit_r;
  logic [2:0]    op_r, op_nxt;
  logic [LW-1:0] flen_r, flen_nxt;
  logic [PW-1:0] strm_addr_r, strm_addr_nxt;
  logic [NW-1:0] strm_cnt_r, strm_cnt_nxt;
  logic [NW-1:0] del_cnt_r, del_cnt_nxt;
  logic          dv_r, dv_nxt;

  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [BW-1:0] out_byte_r;
  logic [LW-1:0] out_flen_r;
  logic          out_last_r;

  logic          out_ld;
  logic [2:0]    ld_status;
  logic [BW-1:0] ld_byte;
  logic [LW-1:0] ld_flen;
  logic          ld_last;

  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic [BW-1:0] wr_data;
  logic          rd_en;
  logic [PW-1:0] rd_addr;
  logic [BW-1:0] rd_data;

  logic [2:0]    in_req;
  logic [LW-1:0] in_len;
  logic [BW-1:0] in_byte;
  logic          acc;
  logic          out_free;
  logic          is_empty;
  logic [SW-1:0] used;
  logic [SW-1:0] free;
  logic [LW-1:0] lim;
  logic [LW-1:0] hdr_len;
  logic          mv;
  logic          issue;

  assign in_req  = in_tuser;
  assign in_len  = in_tdata[6:0];
  assign in_byte = in_tdata[14:7];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign acc       = in_tvalid && in_tready;

  assign is_empty = (read_r == commit_r);

  always_comb begin
    used = SW'(commit_r) - SW'(read_r);
    if (commit_r < read_r) begin
      used = used + SW'(RING_BYTES);
    end
    free = SW'(RING_BYTES - vrrq_pkg::RESERVE_BYTES) - used;
  end

  assign lim = (limit_r > LW'(vrrq_pkg::LIMIT_CAP)) ? LW'(vrrq_pkg::LIMIT_CAP) : limit_r;
  assign hdr_len = rd_data[LW-1:0];

  vrrq_ram #(
    .WIDTH (BW),
    .DEPTH (RING_BYTES),
    .AW    (PW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    read_nxt      = read_r;
    commit_nxt    = commit_r;
    fill_nxt      = fill_r;
    pend_nxt      = pend_r;
    op_nxt        = op_r;
    flen_nxt      = flen_r;
    strm_addr_nxt = strm_addr_r;
    strm_cnt_nxt  = strm_cnt_r;
    del_cnt_nxt   = del_cnt_r;
    dv_nxt        = dv_r;
    out_ld        = 1'b0;
    ld_status     = vrrq_pkg::ST_OK;
    ld_byte       = '0;
    ld_flen       = '0;
    ld_last       = 1'b1;
    wr_en         = 1'b0;
    wr_addr       = fill_r;
    wr_data       = in_byte;
    rd_en         = 1'b0;
    rd_addr       = strm_addr_r;
    mv            = 1'b0;
    issue         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (in_req) inside
            vrrq_pkg::REQ_OPEN: begin
              pend_nxt = '0;
              fill_nxt = commit_r;
              out_ld   = 1'b1;
              if (in_len <= LW'(vrrq_pkg::HEADER_BYTES) || in_len > lim) begin
                ld_status = vrrq_pkg::ST_BAD_LEN;
              end else if (free < SW'(in_len)) begin
                ld_status = vrrq_pkg::ST_NO_ROOM;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = commit_r;
                wr_data  = BW'(in_len);
                fill_nxt = adv(commit_r, LW'(vrrq_pkg::HEADER_BYTES));
                pend_nxt = NW'(in_len - LW'(vrrq_pkg::HEADER_BYTES));
              end
            end
            vrrq_pkg::REQ_DATA: begin
              out_ld = 1'b1;
              if (pend_r == '0) begin
                ld_status = vrrq_pkg::ST_NO_OPEN;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = fill_r;
                fill_nxt = adv(fill_r, LW'(1));
                pend_nxt = pend_r - NW'(1);
                if (pend_r == NW'(1)) begin
                  commit_nxt = adv(fill_r, LW'(1));
                end
              end
            end
            vrrq_pkg::REQ_POP, vrrq_pkg::REQ_PEEK, vrrq_pkg::REQ_DISCARD: begin
              if (is_empty) begin
                out_ld    = 1'b1;
                ld_status = vrrq_pkg::ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = read_r;
                op_nxt    = in_req;
                state_nxt = S_HDR;
              end
            end
            default: begin
              out_ld = 1'b1;
            end
          endcase
        end
      end
      S_HDR: begin
        if (op_r == vrrq_pkg::REQ_DISCARD) begin
          if (out_free) begin
            read_nxt  = adv(read_r, hdr_len);
            out_ld    = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          flen_nxt      = hdr_len;
          strm_addr_nxt = adv(read_r, LW'(vrrq_pkg::HEADER_BYTES));
          strm_cnt_nxt  = NW'(hdr_len - LW'(vrrq_pkg::HEADER_BYTES));
          del_cnt_nxt   = NW'(hdr_len - LW'(vrrq_pkg::HEADER_BYTES));
          dv_nxt        = 1'b0;
          if (op_r == vrrq_pkg::REQ_POP) begin
            read_nxt = adv(read_r, hdr_len);
          end
          state_nxt = S_STRM;
        end
      end
      S_STRM: begin
        mv    = dv_r && out_free;
        issue = (strm_cnt_r != '0) && (!dv_r || mv);
        if (mv) begin
          out_ld      = 1'b1;
          ld_byte     = rd_data;
          ld_flen     = flen_r;
          ld_last     = (del_cnt_r == NW'(1));
          del_cnt_nxt = del_cnt_r - NW'(1);
          if (del_cnt_r == NW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
        if (issue) begin
          rd_en         = 1'b1;
          rd_addr       = strm_addr_r;
          strm_addr_nxt = adv(strm_addr_r, LW'(1));
          strm_cnt_nxt  = strm_cnt_r - NW'(1);
        end
        dv_nxt = issue ? 1'b1 : (mv ? 1'b0 : dv_r);
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      read_r      <= '0;
      commit_r    <= '0;
      fill_r      <= '0;
      pend_r      <= '0;
      limit_r     <= LW'(vrrq_pkg::LIMIT_RESET);
      strm_cnt_r  <= '0;
      del_cnt_r   <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      read_r     <= read_nxt;
      commit_r   <= commit_nxt;
      fill_r     <= fill_nxt;
      pend_r     <= pend_nxt;
      strm_cnt_r <= strm_cnt_nxt;
      del_cnt_r  <= del_cnt_nxt;
      dv_r       <= dv_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    flen_r      <= flen_nxt;
    strm_addr_r <= strm_addr_nxt;
    if (out_ld) begin
      out_status_r <= ld_status;
      out_byte_r   <= ld_byte;
      out_flen_r   <= ld_flen;
      out_last_r   <= ld_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'b0, is_empty, vrrq_pkg::FREE_W'(free), out_flen_r, out_byte_r};

  a_strm_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STRM) |-> (strm_cnt_r <= del_cnt_r))
    else $error("issued reads outrun delivered bytes");

  a_dv_in_strm: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r |-> (state_r == S_STRM))
    else $error("read data pending outside stream state");

  a_pend_cap: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= NW'(vrrq_pkg::LIMIT_CAP - vrrq_pkg::HEADER_BYTES))
    else $error("pending byte count above record cap");

  a_commit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_req == vrrq_pkg::REQ_DATA && pend_r == NW'(1)) |=> (read_r != commit_r))
    else $error("queue empty right after a record commit");

endmodule
`default_nettype wire

[hw/rtl/vrrq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while rd_en is low. No dependencies.
`default_nettype none
module vrrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire
